[hdl/biou_pkg.sv]
// ---------------------------------------------------------------------------
// biou_pkg
// Shared widths, types and axis clip/overlap functions for the box IoU unit.
// ---------------------------------------------------------------------------
package biou_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int AREA_BITS  = 2 * SIZE_BITS;
  localparam int UNI_BITS   = AREA_BITS + 1;
  localparam int NUM_BITS   = AREA_BITS + FRAC_BITS;
  localparam int OUT_BITS   = FRAC_BITS + 1;
  localparam int IN_BITS    = 4 * COORD_BITS + 4 * SIZE_BITS;
  localparam int IN_BYTES   = (IN_BITS + 7) / 8;
  localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]         size_t_;
  typedef logic [AREA_BITS-1:0]         area_t;
  typedef logic [UNI_BITS-1:0]          uni_t;

  // One clipped axis of one box: start is non-negative after clipping.
  typedef struct packed {
    logic [SIZE_BITS-1:0] start;
    logic [SIZE_BITS-1:0] size;
  } seg_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    size_t_ a_w;
    size_t_ a_h;
    coord_t b_x;
    coord_t b_y;
    size_t_ b_w;
    size_t_ b_h;
  } boxes_t;

  // Clip an axis; kill is set when the box ends before zero.
  function automatic logic [2*SIZE_BITS:0] clip_axis(coord_t start, size_t_ size);
    logic signed [COORD_BITS:0] sum;
    logic [SIZE_BITS-1:0] st;
    logic [SIZE_BITS-1:0] sz;
    logic kill;
    sum  = $signed({start[COORD_BITS-1], start}) + $signed({2'b00, size});
    kill = 1'b0;
    st   = start[SIZE_BITS-1:0];
    sz   = size;
    if (start[COORD_BITS-1]) begin
      kill = sum[COORD_BITS];
      st   = '0;
      sz   = sum[SIZE_BITS-1:0];
    end
    return {kill, st, sz};
  endfunction

  // Strict overlap length of two clipped segments; zero when apart.
  function automatic logic [SIZE_BITS-1:0] overlap(seg_t a, seg_t b);
    logic [SIZE_BITS:0] a1;
    logic [SIZE_BITS:0] b1;
    logic [SIZE_BITS:0] lo;
    logic [SIZE_BITS:0] hi;
    logic [SIZE_BITS:0] d;
    a1 = {1'b0, a.start} + {1'b0, a.size};
    b1 = {1'b0, b.start} + {1'b0, b.size};
    lo = (a.start > b.start) ? {1'b0, a.start} : {1'b0, b.start};
    hi = (a1 < b1) ? a1 : b1;
    d  = hi - lo;
    if (!(a1 > {1'b0, b.start} && b1 > {1'b0, a.start})) begin
      d = '0;
    end
    return d[SIZE_BITS-1:0];
  endfunction

endpackage

[hdl/biou_geom.sv]
// ---------------------------------------------------------------------------
// biou_geom
// Front stages: clip both boxes, find overlap lengths, then form the three
// areas with one multiplier each and the union.
// ---------------------------------------------------------------------------
module biou_geom
  import biou_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  boxes_t boxes,
  output logic   out_valid,
  output area_t  inter,
  output uni_t   uni
);

  logic [2*SIZE_BITS:0] cax, cay, cbx, cby;
  seg_t ax, ay, bx, by;
  logic kill;

  // stage 1 registers
  logic v1;
  logic zero1;
  logic [SIZE_BITS-1:0] ix1, iy1;
  size_t_ aw1, ah1, bw1, bh1;

  // stage 2 registers
  logic v2;
  area_t area_a2, area_b2, inter2;

  always_comb begin
    cax  = clip_axis(boxes.a_x, boxes.a_w);
    cay  = clip_axis(boxes.a_y, boxes.a_h);
    cbx  = clip_axis(boxes.b_x, boxes.b_w);
    cby  = clip_axis(boxes.b_y, boxes.b_h);
    ax   = cax[2*SIZE_BITS-1:0];
    ay   = cay[2*SIZE_BITS-1:0];
    bx   = cbx[2*SIZE_BITS-1:0];
    by   = cby[2*SIZE_BITS-1:0];
    kill = cax[2*SIZE_BITS] | cay[2*SIZE_BITS] | cbx[2*SIZE_BITS] | cby[2*SIZE_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
    if (en) begin
      zero1 <= kill;
      ix1   <= overlap(ax, bx);
      iy1   <= overlap(ay, by);
      aw1   <= ax.size;
      ah1   <= ay.size;
      bw1   <= bx.size;
      bh1   <= by.size;
      area_a2 <= AREA_BITS'(aw1) * AREA_BITS'(ah1);
      area_b2 <= AREA_BITS'(bw1) * AREA_BITS'(bh1);
      // a killed item has zero intersection, which forces a zero quotient
      inter2  <= zero1 ? '0 : AREA_BITS'(ix1) * AREA_BITS'(iy1);
    end
  end

  assign out_valid = v2;
  assign inter     = inter2;
  assign uni       = {1'b0, area_a2} + {1'b0, area_b2} - {1'b0, inter2};

endmodule

[hdl/biou_div.sv]
// ---------------------------------------------------------------------------
// biou_div
// Pipelined restoring divider: one quotient bit per stage, floor of
// (inter << FRAC_BITS) / uni, zero for a zero union.
// ---------------------------------------------------------------------------
module biou_div
  import biou_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  area_t               inter,
  input  uni_t                uni,
  output logic                out_valid,
  output logic [OUT_BITS-1:0] quot
);

  localparam int STEPS = OUT_BITS;
  localparam int REM_BITS = UNI_BITS + 1;

  // inter <= uni, so inter << FRAC_BITS over uni fits OUT_BITS quotient bits;
  // start with the remainder holding inter and shift in FRAC_BITS zeros.
  logic                v   [1:STEPS];
  logic [UNI_BITS-1:0] rem [1:STEPS];
  logic [UNI_BITS-1:0] dv  [1:STEPS];
  logic [OUT_BITS-1:0] q   [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic                v_in;
    logic [UNI_BITS-1:0] rem_in;
    logic [UNI_BITS-1:0] dv_in;
    logic [OUT_BITS-1:0] q_in;
    logic [REM_BITS-1:0] trial;
    logic [REM_BITS-1:0] shifted;
    logic                take;
    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign dv_in  = uni;
      assign q_in   = '0;
      // first step compares inter itself against the divisor
      assign rem_in = {1'b0, inter};
    end else begin : g_next
      assign v_in   = v[i];
      assign dv_in  = dv[i];
      assign q_in   = q[i];
      assign rem_in = rem[i];
    end
    always_comb begin
      shifted = (i == 0) ? {1'b0, rem_in} : {rem_in, 1'b0};
      take    = (dv_in != '0) && (shifted >= {1'b0, dv_in});
      trial   = shifted - {1'b0, dv_in};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v_in;
      end
      if (en) begin
        dv[i+1]  <= dv_in;
        rem[i+1] <= take ? trial[UNI_BITS-1:0] : shifted[UNI_BITS-1:0];
        q[i+1]   <= {q_in[OUT_BITS-2:0], take};
      end
    end
  end

  assign out_valid = v[STEPS];
  assign quot      = q[STEPS];

endmodule

[hdl/box_iou_integer_unit.sv]
// ---------------------------------------------------------------------------
// box_iou_integer_unit
// Box-pair intersection over union, integer boxes, Q1.16 result.
// ---------------------------------------------------------------------------
// Pipeline: 2 geometry stages, 17 divider stages and 1 output register.
// Throughput: one box pair per cycle; the whole pipe advances unless the
// output register holds a word that is not taken.
// Reset (rst, synchronous): clears all valid bits; no state otherwise.
module box_iou_integer_unit
  import biou_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // box_a_x, box_a_y, box_a_width, box_a_height,
  // box_b_x, box_b_y, box_b_width, box_b_height (from bit 0), zero fill
  input  logic [8*IN_BYTES-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // overlap_ratio, zero fill
  output logic [8*OUT_BYTES-1:0] m_axis_tdata
);

  boxes_t boxes;
  logic   en;
  logic   gv, dvld;
  area_t  inter;
  uni_t   uni;
  logic [OUT_BITS-1:0] quot;
  logic [OUT_BITS-1:0] ratio;
  logic   ovalid;

  localparam int W = COORD_BITS;
  localparam int S = SIZE_BITS;

  assign boxes.a_x = s_axis_tdata[W-1:0];
  assign boxes.a_y = s_axis_tdata[2*W-1:W];
  assign boxes.a_w = s_axis_tdata[2*W+S-1:2*W];
  assign boxes.a_h = s_axis_tdata[2*W+2*S-1:2*W+S];
  assign boxes.b_x = s_axis_tdata[3*W+2*S-1:2*W+2*S];
  assign boxes.b_y = s_axis_tdata[4*W+2*S-1:3*W+2*S];
  assign boxes.b_w = s_axis_tdata[4*W+3*S-1:4*W+2*S];
  assign boxes.b_h = s_axis_tdata[4*W+4*S-1:4*W+3*S];

  // advance while the output register is empty or being drained
  assign en            = !ovalid || m_axis_tready;
  assign s_axis_tready = en;

  biou_geom u_geom (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_axis_tvalid),
    .boxes(boxes),
    .out_valid(gv), .inter(inter), .uni(uni)
  );

  biou_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(gv), .inter(inter), .uni(uni),
    .out_valid(dvld), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (en) begin
      ovalid <= dvld;
    end
    if (en) begin
      ratio <= quot;
    end
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = {{(8*OUT_BYTES-OUT_BITS){1'b0}}, ratio};

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the box IoU unit: drives box pairs on the input
// stream, predicts each Q1.16 overlap ratio and checks results in order.
// ---------------------------------------------------------------------------
module tb;
  import biou_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // box_a_x, box_a_y, box_a_width, box_a_height,
  // box_b_x, box_b_y, box_b_width, box_b_height (from bit 0), zero fill
  logic [8*IN_BYTES-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // overlap_ratio, zero fill
  logic [8*OUT_BYTES-1:0] m_axis_tdata;

  logic [OUT_BITS-1:0] ratio_q[$];
  int unsigned         mismatches;
  bit                  calm;       // no idling on either side
  int unsigned         hold_req;   // receiver hold-off cycles requested
  int unsigned         quiet;

  box_iou_integer_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Clip one axis to the non-negative side; returns 0 when wholly before zero.
  function automatic bit clip_seg(input longint s, input longint z,
                                  output longint so, output longint zo);
    so = s;
    zo = z;
    if (s < 0) begin
      if (s + z < 0) return 1'b0;
      zo = z + s;
      so = 0;
    end
    return 1'b1;
  endfunction

  function automatic longint seg_overlap(longint a0, longint a1, longint b0, longint b1);
    longint lo;
    longint hi;
    if (!(a1 > b0 && b1 > a0)) return 0;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return hi - lo;
  endfunction

  function automatic logic [OUT_BITS-1:0] iou_ratio(boxes_t p);
    longint ax, ay, aw, ah, bx, by, bw, bh, ix, iy, inter, uni;
    bit ok;
    ok = clip_seg(longint'(p.a_x), longint'(p.a_w), ax, aw);
    ok = ok & clip_seg(longint'(p.a_y), longint'(p.a_h), ay, ah);
    ok = ok & clip_seg(longint'(p.b_x), longint'(p.b_w), bx, bw);
    ok = ok & clip_seg(longint'(p.b_y), longint'(p.b_h), by, bh);
    if (!ok) return '0;
    ix = seg_overlap(ax, ax + aw, bx, bx + bw);
    if (ix <= 0) return '0;
    iy = seg_overlap(ay, ay + ah, by, by + bh);
    if (iy <= 0) return '0;
    inter = ix * iy;
    uni   = aw * ah + bw * bh - inter;
    if (uni == 0) return '0;
    return OUT_BITS'((inter << FRAC_BITS) / uni);
  endfunction

  function automatic logic [8*IN_BYTES-1:0] pack_boxes(boxes_t p);
    return {{(8*IN_BYTES-IN_BITS){1'b0}},
            p.b_h, p.b_w, p.b_y, p.b_x, p.a_h, p.a_w, p.a_y, p.a_x};
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Offer one pair; hold it until taken, then maybe idle.
  task automatic send_pair(boxes_t p);
    bit ok;
    s_axis_tdata  <= pack_boxes(p);
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      ok = s_axis_tvalid && s_axis_tready;
      @(posedge clk);
    end while (!ok);
    ratio_q.push_back(iou_ratio(p));
    if (!calm) begin
      while ($urandom_range(0, 99) < 32) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic boxes_t mk(int ax, int ay, int aw, int ah,
                                int bx, int by, int bw, int bh);
    boxes_t p;
    p.a_x = coord_t'(ax); p.a_y = coord_t'(ay);
    p.a_w = size_t_'(aw); p.a_h = size_t_'(ah);
    p.b_x = coord_t'(bx); p.b_y = coord_t'(by);
    p.b_w = size_t_'(bw); p.b_h = size_t_'(bh);
    return p;
  endfunction

  function automatic boxes_t rand_pair();
    boxes_t p;
    int kind;
    int span;
    kind = $urandom_range(0, 9);
    p = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (kind >= 2) begin
      span = (kind == 7) ? 32767 : 300;
      p.a_x = coord_t'(int'($urandom_range(0, 2 * span)) - span / 2);
      p.a_y = coord_t'(int'($urandom_range(0, 2 * span)) - span / 2);
      p.a_w = size_t_'($urandom_range(0, span));
      p.a_h = size_t_'($urandom_range(0, span));
      p.b_x = coord_t'(int'(p.a_x) + int'($urandom_range(0, 2 * span)) - span);
      p.b_y = coord_t'(int'(p.a_y) + int'($urandom_range(0, 2 * span)) - span);
      p.b_w = size_t_'($urandom_range(0, span));
      p.b_h = size_t_'($urandom_range(0, span));
    end
    if (kind == 8) begin
      // identical boxes, or B touching A on the right
      p.b_y = p.a_y; p.b_w = p.a_w; p.b_h = p.a_h;
      p.b_x = $urandom_range(0, 1) ? p.a_x : coord_t'(int'(p.a_x) + int'(p.a_w));
    end
    return p;
  endfunction

  // Check each word as it is taken.
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (ratio_q.size() == 0) begin
        report_mismatch($sformatf("unexpected ratio %0d", m_axis_tdata[OUT_BITS-1:0]));
      end else begin
        if (m_axis_tdata[OUT_BITS-1:0] !== ratio_q[0])
          report_mismatch($sformatf("overlap_ratio got %0d exp %0d",
                                    m_axis_tdata[OUT_BITS-1:0], ratio_q[0]));
        if (m_axis_tdata[8*OUT_BYTES-1:OUT_BITS] !== '0)
          report_mismatch("fill bits not zero");
        void'(ratio_q.pop_front());
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req != 0) begin
      m_axis_tready <= 1'b0;
      hold_req <= hold_req - 1;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(negedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk(0, 0, 32767, 32767, 0, 0, 32767, 32767));
    send_pair(mk(10, 10, 20, 20, 10, 10, 20, 20));
    send_pair(mk(0, 0, 10, 10, 10, 0, 10, 10));        // touching on x
    send_pair(mk(0, 0, 10, 10, 0, 10, 10, 10));        // touching on y
    send_pair(mk(-5, 0, 4, 10, 0, 0, 10, 10));         // A wholly left of zero
    send_pair(mk(0, -5, 10, 4, 0, 0, 10, 10));
    send_pair(mk(0, 0, 10, 10, -9, 0, 3, 10));
    send_pair(mk(0, 0, 10, 10, 0, -9, 10, 3));
    send_pair(mk(-5, 0, 5, 10, 0, 0, 10, 10));         // clips to size zero
    send_pair(mk(-5, -5, 15, 15, 0, 0, 10, 10));       // clipping to full overlap
    send_pair(mk(-32768, -32768, 32767, 32767, 0, 0, 5, 5));
    send_pair(mk(-32768, 0, 32767, 32767, -32768, 0, 32767, 32767));
    send_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(mk(32767, 32767, 32767, 32767, 32766, 32766, 2, 2));
    send_pair(mk(0, 0, 32767, 32767, 32766, 32766, 1, 1));
    send_pair(mk(0, 0, 1, 1, 0, 0, 32767, 32767));
    send_pair(mk(0, 0, 3, 3, 1, 1, 3, 3));
    send_pair(mk(0, 0, 10, 0, 0, 0, 10, 10));          // zero height
    send_pair(mk(5, 5, 10, 10, 0, 0, 30, 30));
    send_pair(mk(-1, -1, 1, 1, -1, -1, 1, 1));
    go_idle();
  endtask

  task automatic test_random(int n);
    repeat (n) send_pair(rand_pair());
    go_idle();
  endtask

  task automatic test_calm_stream(int n);
    calm = 1'b1;
    repeat (n) send_pair(rand_pair());
    go_idle();
    calm = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering: pipe fills, input stalls.
  task automatic test_backpressure();
    calm = 1'b1;
    hold_req = 150;
    repeat (60) send_pair(rand_pair());
    go_idle();
    calm = 1'b0;
  endtask

  // Sender pauses until every result is back.
  task automatic test_drain_pause();
    while (ratio_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    test_random(100);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    calm          = 1'b0;
    hold_req      = 0;
    mismatches    = 0;
    quiet         = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_calm_stream(300);
    test_drain_pause();
    test_random(400);
    while (ratio_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && ratio_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
